### design/vsavp_pkg.sv
// shared types, constants and the control program of the axis velocity profiler
// no dependencies; every design module imports this package
package vsavp_pkg;

  // field and datapath widths
  localparam int ErrW     = 20;
  localparam int NearW    = 19;
  localparam int ValW     = 32;
  localparam int FracW    = 32;
  localparam int ProdW    = 2 * ValW;
  localparam int StepW    = 33;
  localparam int DataW    = 32;
  localparam int AddrW    = 5;
  localparam int PcW      = 5;
  localparam int CntW     = 5;
  localparam int DivSteps = ValW;

  // register indexes on the config port
  localparam logic [2:0] RegSpeedLimit  = 3'd0;
  localparam logic [2:0] RegAccelLimit  = 3'd1;
  localparam logic [2:0] RegSpeedFloor  = 3'd2;
  localparam logic [2:0] RegSettleSpeed = 3'd3;
  localparam logic [2:0] RegNearError   = 3'd4;
  localparam logic [2:0] RegFullScale   = 3'd5;
  localparam logic [2:0] RegStepTime    = 3'd6;

  // register reset values
  localparam logic [ValW-1:0]        RstSpeedLimit  = 32'd214748365;
  localparam logic [ValW-1:0]        RstAccelLimit  = 32'd257698038;
  localparam logic [ValW-1:0]        RstSpeedFloor  = 32'd6442451;
  localparam logic [ValW-1:0]        RstSettleSpeed = 32'd6442451;
  localparam logic [NearW-1:0]       RstNearError   = 19'd25;
  localparam logic signed [ErrW-1:0] RstFullScale   = 20'sd300;
  localparam logic [ValW-1:0]        RstStepTime    = 32'd214748365;

  // program labels
  localparam logic [PcW-1:0] PcDivStep = 5'd4;
  localparam logic [PcW-1:0] PcHold    = 5'd16;
  localparam logic [PcW-1:0] PcSettled = 5'd17;

  // multiplier operand selection
  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_SL_EMAG,
    MUL_ACC_T,
    MUL_AT_T,
    MUL_CS_T
  } mul_sel_t;

  // datapath operation of one step
  typedef enum logic [3:0] {
    OP_NOP,
    OP_DIV_LOAD,
    OP_DIV_STEP,
    OP_VACT_SEL,
    OP_VACT_FLOOR,
    OP_VACT_CLAMP,
    OP_LD_AT,
    OP_FLAGS,
    OP_LD_AT2H,
    OP_LD_VT,
    OP_DECIDE,
    OP_APPLY1,
    OP_APPLY2,
    OP_EMIT,
    OP_EMIT_HOLD,
    OP_EMIT_SETTLED
  } op_t;

  // branch condition of one step
  typedef enum logic [2:0] {
    BR_NONE,
    BR_NOT_OK,
    BR_SETTLE,
    BR_LOOP,
    BR_END
  } br_t;

  typedef struct packed {
    mul_sel_t       mul;
    op_t            op;
    br_t            br;
    logic [PcW-1:0] target;
  } ctl_t;

  // status from datapath to sequencer
  typedef struct packed {
    logic not_ok;
    logic settle;
  } flags_t;

  typedef struct packed {
    logic [ValW-1:0]        speed_limit;
    logic [ValW-1:0]        accel_limit;
    logic [ValW-1:0]        speed_floor;
    logic [ValW-1:0]        settle_speed;
    logic [NearW-1:0]       near_error;
    logic signed [ErrW-1:0] full_scale_error;
    logic [ValW-1:0]        step_time;
  } cfg_t;

  typedef struct packed {
    logic signed [StepW-1:0] position_step;
    logic [ValW-1:0]         speed;
    logic                    settled;
    logic                    target_reached;
  } res_t;

  localparam ctl_t CtlIdle = '{mul: MUL_NONE, op: OP_NOP, br: BR_NONE, target: '0};

  // control store: one word per step
  function automatic ctl_t prog_word(input logic [PcW-1:0] pc);
    ctl_t w;
    w = CtlIdle;
    unique case (pc)
      5'd0:  w = '{mul: MUL_NONE,    op: OP_NOP,          br: BR_NOT_OK, target: PcHold};
      5'd1:  w = '{mul: MUL_NONE,    op: OP_NOP,          br: BR_SETTLE, target: PcSettled};
      5'd2:  w = '{mul: MUL_SL_EMAG, op: OP_NOP,          br: BR_NONE,   target: '0};
      5'd3:  w = '{mul: MUL_NONE,    op: OP_DIV_LOAD,     br: BR_NONE,   target: '0};
      5'd4:  w = '{mul: MUL_NONE,    op: OP_DIV_STEP,     br: BR_LOOP,   target: PcDivStep};
      5'd5:  w = '{mul: MUL_NONE,    op: OP_VACT_SEL,     br: BR_NONE,   target: '0};
      5'd6:  w = '{mul: MUL_NONE,    op: OP_VACT_FLOOR,   br: BR_NONE,   target: '0};
      5'd7:  w = '{mul: MUL_ACC_T,   op: OP_VACT_CLAMP,   br: BR_NONE,   target: '0};
      5'd8:  w = '{mul: MUL_NONE,    op: OP_LD_AT,        br: BR_NONE,   target: '0};
      5'd9:  w = '{mul: MUL_AT_T,    op: OP_FLAGS,        br: BR_NONE,   target: '0};
      5'd10: w = '{mul: MUL_CS_T,    op: OP_LD_AT2H,      br: BR_NONE,   target: '0};
      5'd11: w = '{mul: MUL_NONE,    op: OP_LD_VT,        br: BR_NONE,   target: '0};
      5'd12: w = '{mul: MUL_NONE,    op: OP_DECIDE,       br: BR_NONE,   target: '0};
      5'd13: w = '{mul: MUL_NONE,    op: OP_APPLY1,       br: BR_NONE,   target: '0};
      5'd14: w = '{mul: MUL_NONE,    op: OP_APPLY2,       br: BR_NONE,   target: '0};
      5'd15: w = '{mul: MUL_NONE,    op: OP_EMIT,         br: BR_END,    target: '0};
      5'd16: w = '{mul: MUL_NONE,    op: OP_EMIT_HOLD,    br: BR_END,    target: '0};
      5'd17: w = '{mul: MUL_NONE,    op: OP_EMIT_SETTLED, br: BR_END,    target: '0};
      default: w = '{mul: MUL_NONE,  op: OP_NOP,          br: BR_END,    target: '0};
    endcase
    return w;
  endfunction

endpackage

### design/vsavp_div.sv
// restoring divider, one quotient bit per step, for the proportional speed limit
// depends on vsavp_pkg; quotient is valid when the high dividend part is below the divisor
module vsavp_div
  import vsavp_pkg::*;
(
  input  logic            clk,
  input  logic            load,
  input  logic            step,
  input  logic [ErrW-1:0] dvd_hi,
  input  logic [ValW-1:0] dvd_lo,
  input  logic [ErrW-1:0] divisor,
  output logic [ValW-1:0] quot
);

  logic [ErrW-1:0] rem_r;
  logic [ValW-1:0] dq_r;
  logic [ErrW:0]   trial;
  logic [ErrW:0]   diff;
  logic            fits;

  // shift one dividend bit into the remainder and try the subtract
  always_comb begin
    trial = {rem_r, dq_r[ValW-1]};
    diff  = trial - {1'b0, divisor};
    fits  = trial >= {1'b0, divisor};
  end

  // remainder and dividend/quotient shift register
  always_ff @(posedge clk) begin
    if (load) begin
      rem_r <= dvd_hi;
      dq_r  <= dvd_lo;
    end else if (step) begin
      rem_r <= fits ? diff[ErrW-1:0] : trial[ErrW-1:0];
      dq_r  <= {dq_r[ValW-2:0], fits};
    end
  end

  assign quot = dq_r;

endmodule

### design/vsavp_seq.sv
// microcode sequencer: step counter, loop counter and conditional jumps
// depends on vsavp_pkg for the control word type and the program table
module vsavp_seq
  import vsavp_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   start,
  input  flags_t flags,
  input  logic   out_free,
  output logic   busy,
  output ctl_t   ctl
);

  typedef enum logic {
    SEQ_IDLE,
    SEQ_RUN
  } seq_state_t;

  seq_state_t      state_r, state_nxt;
  logic [PcW-1:0]  pc_r, pc_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  ctl_t            word;
  logic            is_emit;
  logic            fire;

  // fetch and stall an emit while the output word is still held
  always_comb begin
    word    = prog_word(pc_r);
    is_emit = (word.op == OP_EMIT) || (word.op == OP_EMIT_HOLD) ||
              (word.op == OP_EMIT_SETTLED);
    fire    = (state_r == SEQ_RUN) && !(is_emit && !out_free);
  end

  // next step
  always_comb begin
    state_nxt = state_r;
    pc_nxt    = pc_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      SEQ_IDLE: begin
        if (start) begin
          state_nxt = SEQ_RUN;
          pc_nxt    = '0;
        end
      end
      SEQ_RUN: begin
        if (fire) begin
          if (word.op == OP_DIV_LOAD) begin
            cnt_nxt = CntW'(DivSteps - 1);
          end
          pc_nxt = pc_r + PcW'(1);
          unique case (word.br)
            BR_NONE: ;
            BR_NOT_OK: begin
              if (flags.not_ok) pc_nxt = word.target;
            end
            BR_SETTLE: begin
              if (flags.settle) pc_nxt = word.target;
            end
            BR_LOOP: begin
              if (cnt_r != '0) begin
                pc_nxt  = word.target;
                cnt_nxt = cnt_r - CntW'(1);
              end
            end
            BR_END: state_nxt = SEQ_IDLE;
            default: state_nxt = SEQ_IDLE;
          endcase
        end
      end
      default: state_nxt = SEQ_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SEQ_IDLE;
      pc_r    <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      pc_r    <= pc_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  assign busy = (state_r == SEQ_RUN);
  assign ctl  = fire ? word : CtlIdle;

endmodule

### design/vsavp_dp.sv
// datapath of the axis profiler: shared multiplier, divider, speed limit and motion update
// depends on vsavp_pkg, vsavp_div; one control word per cycle from vsavp_seq, bar stalls
module vsavp_dp
  import vsavp_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   load,
  input  logic signed [ErrW-1:0] in_error,
  input  logic                   in_tracking,
  input  logic                   in_report_ok,
  input  cfg_t                   cfg,
  input  ctl_t                   ctl,
  output flags_t                 flags,
  output logic                   res_load,
  output res_t                   res
);

  typedef enum logic [1:0] {
    MODE_COAST,
    MODE_ACCEL,
    MODE_BRAKE
  } mode_t;

  // item word
  logic [ErrW-1:0] emag_r;
  logic            eneg_r, trk_r, ok_r;
  // axis state
  logic [ValW-1:0] cs_r;
  logic            dir_r, reached_r;
  // working registers
  logic [ProdW-1:0] prod_r;
  logic [ValW-1:0]  vact_r, at_r, at2h_r, vt_r, smag_r;
  logic [ValW:0]    sum_r, tmp_r;
  logic             change_r;
  mode_t            mode_r;

  logic [ErrW-1:0]  err_u, emag_in, fs_u, fs_mag;
  logic [ValW-1:0]  mul_a, mul_b, quot, sum_sat;
  logic [ErrW+1:0]  emag5;
  logic             cs_zero, accel_c, brake_c;

  // magnitudes of the input error and of the full scale error
  always_comb begin
    err_u   = in_error;
    emag_in = err_u[ErrW-1] ? (~err_u + ErrW'(1)) : err_u;
    fs_u    = cfg.full_scale_error;
    fs_mag  = fs_u[ErrW-1] ? (~fs_u + ErrW'(1)) : fs_u;
  end

  // settling test and report check for the sequencer
  always_comb begin
    emag5        = ({2'b00, emag_r} << 2) + {2'b00, emag_r};
    flags.not_ok = !ok_r;
    flags.settle = ok_r && trk_r && reached_r && (cs_r <= cfg.settle_speed) &&
                   (emag5 < {3'b000, cfg.near_error});
  end

  // multiplier operands
  always_comb begin
    unique case (ctl.mul)
      MUL_SL_EMAG: begin mul_a = cfg.speed_limit; mul_b = ValW'(emag_r);   end
      MUL_ACC_T:   begin mul_a = cfg.accel_limit; mul_b = cfg.step_time;   end
      MUL_AT_T:    begin mul_a = at_r;            mul_b = cfg.step_time;   end
      MUL_CS_T:    begin mul_a = cs_r;            mul_b = cfg.step_time;   end
      default:     begin mul_a = '0;              mul_b = '0;              end
    endcase
  end

  // motion mode decision
  always_comb begin
    cs_zero = (cs_r == '0);
    accel_c = trk_r && (cs_zero || ((cs_r < cfg.speed_limit) && !change_r && !reached_r));
    brake_c = !cs_zero && (change_r || reached_r || !trk_r || (cs_r > vact_r));
    sum_sat = sum_r[ValW] ? '1 : sum_r[ValW-1:0];
  end

  vsavp_div u_div (
    .clk     (clk),
    .load    (ctl.op == OP_DIV_LOAD),
    .step    (ctl.op == OP_DIV_STEP),
    .dvd_hi  (prod_r[ValW +: ErrW]),
    .dvd_lo  (prod_r[ValW-1:0]),
    .divisor (fs_mag),
    .quot    (quot)
  );

  // item capture
  always_ff @(posedge clk) begin
    if (load) begin
      emag_r <= emag_in;
      eneg_r <= in_error[ErrW-1];
      trk_r  <= in_tracking;
      ok_r   <= in_report_ok;
    end
  end

  // shared multiplier, product registered
  always_ff @(posedge clk) begin
    if (ctl.mul != MUL_NONE) begin
      prod_r <= {{ValW{1'b0}}, mul_a} * {{ValW{1'b0}}, mul_b};
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    unique case (ctl.op)
      OP_VACT_SEL:   vact_r <= (emag_r >= fs_mag) ? cfg.speed_limit : quot;
      OP_VACT_FLOOR: if (vact_r < cfg.speed_floor) vact_r <= cfg.speed_floor;
      OP_VACT_CLAMP: if (vact_r > cfg.speed_limit) vact_r <= cfg.speed_limit;
      OP_LD_AT:      at_r <= prod_r[FracW +: ValW];
      OP_FLAGS:      change_r <= (emag_r == '0) || (eneg_r != dir_r);
      OP_LD_AT2H:    at2h_r <= {1'b0, prod_r[FracW+1 +: ValW-1]};
      OP_LD_VT:      vt_r <= prod_r[FracW +: ValW];
      OP_DECIDE: begin
        sum_r <= {1'b0, at2h_r} + {1'b0, vt_r};
        priority if (accel_c) mode_r <= MODE_ACCEL;
        else if (brake_c)     mode_r <= MODE_BRAKE;
        else                  mode_r <= MODE_COAST;
      end
      OP_APPLY1: begin
        // accelerate adds, brake subtracts with the borrow kept on top
        if (mode_r == MODE_ACCEL)      tmp_r <= {1'b0, cs_r} + {1'b0, at_r};
        else if (mode_r == MODE_BRAKE) tmp_r <= {1'b0, cs_r} - {1'b0, at_r};
      end
      OP_APPLY2: begin
        unique case (mode_r)
          MODE_ACCEL: smag_r <= sum_sat;
          MODE_BRAKE: smag_r <= tmp_r[ValW] ? '0 : sum_sat;
          MODE_COAST: smag_r <= vt_r;
          default:    smag_r <= vt_r;
        endcase
      end
      default: ;
    endcase
  end

  // axis state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cs_r      <= '0;
      dir_r     <= 1'b0;
      reached_r <= 1'b0;
    end else begin
      unique case (ctl.op)
        OP_FLAGS: begin
          reached_r <= emag_r < {1'b0, cfg.near_error};
          if (((emag_r == '0) || (eneg_r != dir_r)) && cs_zero && (emag_r != '0)) begin
            dir_r <= eneg_r;
          end
        end
        OP_APPLY2: begin
          if (mode_r == MODE_ACCEL) begin
            cs_r <= (tmp_r > {1'b0, vact_r}) ? vact_r : tmp_r[ValW-1:0];
          end else if (mode_r == MODE_BRAKE) begin
            cs_r <= tmp_r[ValW] ? '0 : tmp_r[ValW-1:0];
          end
        end
        default: ;
      endcase
    end
  end

  // result word; a positive direction gives a negative step
  always_comb begin
    res_load = (ctl.op == OP_EMIT) || (ctl.op == OP_EMIT_HOLD) ||
               (ctl.op == OP_EMIT_SETTLED);
    res.speed          = cs_r;
    res.target_reached = reached_r;
    res.settled        = (ctl.op == OP_EMIT_SETTLED);
    if (ctl.op != OP_EMIT) begin
      res.position_step = '0;
    end else if ((smag_r != '0) && !dir_r) begin
      res.position_step = -$signed({1'b0, smag_r});
    end else begin
      res.position_step = $signed({1'b0, smag_r});
    end
  end

endmodule

### design/visual_servo_axis_velocity_profiler.sv
// top level of one servo axis velocity profiler: config registers, handshakes, output word
// depends on vsavp_pkg, vsavp_seq, vsavp_dp
//
//   channel  ports                                    transfer
//   in       in_valid/in_stall, error/tracking/ok     word taken when valid and not stall
//   out      out_valid/out_stall, step/speed/flags    word taken when valid and not stall
//   cfg      psel/penable/pwrite/paddr/pwdata/prdata  write in access phase, pready high
//
// a full update runs from accept through the divider loop, one step per quotient bit, until
//   the sequencer is free again; invalid reports and settled axes skip the divider loop
// reset clears the axis state, the sequencer and the output valid; registers take defaults
// a stalled output holds the emit step; a new word is taken once the emit has been done
module visual_servo_axis_velocity_profiler
  import vsavp_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  // input channel
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic signed [ErrW-1:0]  in_error,
  input  logic                    in_tracking,
  input  logic                    in_report_ok,
  // result channel
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [StepW-1:0] out_position_step,
  output logic [ValW-1:0]         out_speed,
  output logic                    out_settled,
  output logic                    out_target_reached,
  // configuration port
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [AddrW-1:0]        paddr,
  input  logic [DataW-1:0]        pwdata,
  output logic [DataW-1:0]        prdata,
  output logic                    pready
);

  cfg_t   cfg_r;
  logic   out_valid_r;
  res_t   res_r;
  logic   seq_busy, accept, out_free, res_load, cfg_wr;
  ctl_t   ctl;
  flags_t flags;
  res_t   res;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign in_stall = seq_busy;
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.speed_limit      <= RstSpeedLimit;
      cfg_r.accel_limit      <= RstAccelLimit;
      cfg_r.speed_floor      <= RstSpeedFloor;
      cfg_r.settle_speed     <= RstSettleSpeed;
      cfg_r.near_error       <= RstNearError;
      cfg_r.full_scale_error <= RstFullScale;
      cfg_r.step_time        <= RstStepTime;
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        RegSpeedLimit:  cfg_r.speed_limit      <= pwdata;
        RegAccelLimit:  cfg_r.accel_limit      <= pwdata;
        RegSpeedFloor:  cfg_r.speed_floor      <= pwdata;
        RegSettleSpeed: cfg_r.settle_speed     <= pwdata;
        RegNearError:   cfg_r.near_error       <= pwdata[NearW-1:0];
        RegFullScale:   cfg_r.full_scale_error <= $signed(pwdata[ErrW-1:0]);
        RegStepTime:    cfg_r.step_time        <= pwdata;
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (paddr[4:2])
      RegSpeedLimit:  prdata = cfg_r.speed_limit;
      RegAccelLimit:  prdata = cfg_r.accel_limit;
      RegSpeedFloor:  prdata = cfg_r.speed_floor;
      RegSettleSpeed: prdata = cfg_r.settle_speed;
      RegNearError:   prdata = {{(DataW-NearW){1'b0}}, cfg_r.near_error};
      RegFullScale:   prdata = {{(DataW-ErrW){cfg_r.full_scale_error[ErrW-1]}},
                                cfg_r.full_scale_error};
      RegStepTime:    prdata = cfg_r.step_time;
      default:        prdata = '0;
    endcase
  end

  vsavp_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (accept),
    .flags    (flags),
    .out_free (out_free),
    .busy     (seq_busy),
    .ctl      (ctl)
  );

  vsavp_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .load         (accept),
    .in_error     (in_error),
    .in_tracking  (in_tracking),
    .in_report_ok (in_report_ok),
    .cfg          (cfg_r),
    .ctl          (ctl),
    .flags        (flags),
    .res_load     (res_load),
    .res          (res)
  );

  // output word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_r <= res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_position_step  = res_r.position_step;
  assign out_speed          = res_r.speed;
  assign out_settled        = res_r.settled;
  assign out_target_reached = res_r.target_reached;

  // one word at a time through the sequencer
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> in_stall)
    else $error("input word taken while the previous one is still in work");

  // a settled axis issues no motion and has reached its target
  a_settled_no_move: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_settled |-> (out_position_step == '0) && out_target_reached)
    else $error("settled result with a nonzero step or without reached flag");

  // an emit never overwrites a word that is still stalled
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    res_load |-> seq_busy && !(out_valid_r && out_stall))
    else $error("result emitted over a stalled output word");

endmodule
